### rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared widths, defaults and codes for the nearest point search unit.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int DEF_TABLE_DEPTH = 4096;
    localparam int DEF_COORD_BITS  = 24;

    localparam int IDX_W    = 12;
    localparam int VCOUNT_W = 13;
    localparam int DIST_W   = 50;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

### rtl/nps_if.sv
// ----------------------------------------------------------------------------
// nps_if
// Request and response channels of the nearest point search unit.
// ----------------------------------------------------------------------------
interface nps_req_if #(
    parameter int COORD_BITS = nps_pkg::DEF_COORD_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [nps_pkg::IDX_W-1:0]     vertex_index;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic signed [COORD_BITS-1:0]  coord_z;

    modport source (
        output valid, operation, vertex_index, coord_x, coord_y, coord_z,
        input  ready
    );
    modport sink (
        input  valid, operation, vertex_index, coord_x, coord_y, coord_z,
        output ready
    );
endinterface

interface nps_rsp_if #(
    parameter int COORD_BITS = nps_pkg::DEF_COORD_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [nps_pkg::IDX_W-1:0]     nearest_index;
    logic signed [COORD_BITS-1:0]  nearest_x;
    logic signed [COORD_BITS-1:0]  nearest_y;
    logic signed [COORD_BITS-1:0]  nearest_z;
    logic [nps_pkg::DIST_W-1:0]    distance_squared;

    modport source (
        output valid, found, nearest_index, nearest_x, nearest_y, nearest_z,
               distance_squared,
        input  ready
    );
    modport sink (
        input  valid, found, nearest_index, nearest_x, nearest_y, nearest_z,
               distance_squared,
        output ready
    );
endinterface

### rtl/nps_ram.sv
// ----------------------------------------------------------------------------
// nps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/nps_dist.sv
// ----------------------------------------------------------------------------
// nps_dist
// Three-stage squared distance unit: difference magnitude, square, sum.
// ----------------------------------------------------------------------------
module nps_dist #(
    parameter int COORD_BITS = nps_pkg::DEF_COORD_BITS,
    parameter int ADDR_W     = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ADDR_W-1:0]             in_idx,
    input  logic [3*COORD_BITS-1:0]       in_point,
    input  logic [3*COORD_BITS-1:0]       in_query,
    output logic                          out_valid,
    output logic [ADDR_W-1:0]             out_idx,
    output logic [3*COORD_BITS-1:0]       out_point,
    output logic [nps_pkg::DIST_W-1:0]    out_dist,
    output logic                          busy
);

    localparam int CB    = COORD_BITS;
    localparam int PT_W  = 3 * CB;
    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = SQ_W + 2;
    localparam int EXT_W = (SUM_W > nps_pkg::DIST_W) ? SUM_W : nps_pkg::DIST_W;

    logic signed [CB:0]  diff [3];
    logic [CB-1:0]       mag_next [3];
    logic [SQ_W-1:0]     sq_next [3];
    logic [SUM_W-1:0]    sum;
    logic [EXT_W-1:0]    sum_ext;
    logic [nps_pkg::DIST_W-1:0] dist_next;

    logic                s1_vld_reg;
    logic [ADDR_W-1:0]   s1_idx_reg;
    logic [PT_W-1:0]     s1_pt_reg;
    logic [CB-1:0]       s1_mag_reg [3];

    logic                s2_vld_reg;
    logic [ADDR_W-1:0]   s2_idx_reg;
    logic [PT_W-1:0]     s2_pt_reg;
    logic [SQ_W-1:0]     s2_sq_reg [3];

    logic                s3_vld_reg;
    logic [ADDR_W-1:0]   s3_idx_reg;
    logic [PT_W-1:0]     s3_pt_reg;
    logic [nps_pkg::DIST_W-1:0] s3_dist_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = $signed({in_point[(2-k)*CB+CB-1], in_point[(2-k)*CB +: CB]})
                    - $signed({in_query[(2-k)*CB+CB-1], in_query[(2-k)*CB +: CB]});
            mag_next[k] = diff[k][CB] ? CB'(-diff[k]) : CB'(diff[k]);
            sq_next[k]  = s1_mag_reg[k] * s1_mag_reg[k];
        end
    end

    assign sum     = SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1]) + SUM_W'(s2_sq_reg[2]);
    assign sum_ext = EXT_W'(sum);
    assign dist_next = (sum_ext >= EXT_W'(nps_pkg::DIST_MAX)) ? nps_pkg::DIST_MAX
                                                             : sum_ext[nps_pkg::DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= in_idx;
        s1_pt_reg   <= in_point;
        s2_idx_reg  <= s1_idx_reg;
        s2_pt_reg   <= s1_pt_reg;
        s3_idx_reg  <= s2_idx_reg;
        s3_pt_reg   <= s2_pt_reg;
        s3_dist_reg <= dist_next;
        for (int k = 0; k < 3; k++)
        begin
            s1_mag_reg[k] <= mag_next[k];
            s2_sq_reg[k]  <= sq_next[k];
        end
    end

    assign out_valid = s3_vld_reg;
    assign out_idx   = s3_idx_reg;
    assign out_point = s3_pt_reg;
    assign out_dist  = s3_dist_reg;
    assign busy      = s1_vld_reg | s2_vld_reg | s3_vld_reg;

endmodule

### rtl/nearest_point_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_search_unit
// Point table with a brute-force nearest point query over the loaded slots.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  req       in   valid/ready     operation, vertex_index, coord_x/y/z
//  rsp       out  valid/ready     found, nearest_index, nearest_x/y/z,
//                                 distance_squared
//  cfg       in   cfg_we          cfg_wdata = vertex_count
//
//  A store beat is taken while the unit is idle. A query holds req.ready low
//  while it scans min(vertex_count, TABLE_DEPTH) slots: one table read per
//  cycle via the single RAM read port feeding the three-stage distance unit.
//  Reset clears the sequencer and the handshake state; table contents are
//  undefined until written. A stalled rsp beat holds in its register while
//  stores are still taken; a finished query waits until the register frees.
// ----------------------------------------------------------------------------
module nearest_point_search_unit #(
    parameter int TABLE_DEPTH = nps_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = nps_pkg::DEF_COORD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nps_pkg::VCOUNT_W-1:0]   cfg_wdata,
    nps_req_if.sink                        req,
    nps_rsp_if.source                      rsp
);

    localparam int CB    = COORD_BITS;
    localparam int PT_W  = 3 * CB;
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = (AW + 1 > nps_pkg::VCOUNT_W) ? AW + 1 : nps_pkg::VCOUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [nps_pkg::VCOUNT_W-1:0] vcount_reg;
    logic [PT_W-1:0]             query_reg, query_next;
    logic [CNT_W-1:0]            scan_len_reg, scan_len_next;
    logic [CNT_W-1:0]            issue_cnt_reg, issue_cnt_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic [AW-1:0]               rd_idx_reg;
    logic                        have_reg, have_next;
    logic [AW-1:0]               best_idx_reg, best_idx_next;
    logic [PT_W-1:0]             best_pt_reg, best_pt_next;
    logic [nps_pkg::DIST_W-1:0]  best_dist_reg, best_dist_next;

    logic                        rsp_valid_reg, rsp_valid_next;
    logic                        rsp_found_reg;
    logic [nps_pkg::IDX_W-1:0]   rsp_idx_reg;
    logic [PT_W-1:0]             rsp_pt_reg;
    logic [nps_pkg::DIST_W-1:0]  rsp_dist_reg;
    logic                        rsp_load;

    logic                        req_fire;
    logic [CNT_W-1:0]            slot_ext;
    logic [CNT_W-1:0]            vcount_ext;
    logic [CNT_W-1:0]            scan_len_calc;
    logic                        ram_we;
    logic                        ram_re;
    logic [PT_W-1:0]             ram_rdata;
    logic [CNT_W-1:0]            best_idx_ext;

    logic                        d_valid;
    logic [AW-1:0]               d_idx;
    logic [PT_W-1:0]             d_pt;
    logic [nps_pkg::DIST_W-1:0]  d_dist;
    logic                        d_busy;
    logic                        d_better;

    assign req.ready     = (state_reg == ST_IDLE);
    assign req_fire      = req.valid && req.ready;
    assign slot_ext      = CNT_W'(req.vertex_index);
    assign vcount_ext    = CNT_W'(vcount_reg);
    assign scan_len_calc = (vcount_ext > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : vcount_ext;

    assign ram_we = req_fire && (req.operation == nps_pkg::OP_STORE)
                 && (slot_ext < CNT_W'(TABLE_DEPTH));
    assign ram_re = (state_reg == ST_SCAN) && (issue_cnt_reg < scan_len_reg);

    nps_ram #(
        .WIDTH (PT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_ext[AW-1:0]),
        .wdata ({req.coord_x, req.coord_y, req.coord_z}),
        .re    (ram_re),
        .raddr (issue_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    nps_dist #(
        .COORD_BITS (COORD_BITS),
        .ADDR_W     (AW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_vld_reg),
        .in_idx    (rd_idx_reg),
        .in_point  (ram_rdata),
        .in_query  (query_reg),
        .out_valid (d_valid),
        .out_idx   (d_idx),
        .out_point (d_pt),
        .out_dist  (d_dist),
        .busy      (d_busy)
    );

    assign d_better     = d_valid && (!have_reg || (d_dist < best_dist_reg));
    assign best_idx_ext = CNT_W'(best_idx_reg);
    assign rsp_load     = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        query_next     = query_reg;
        scan_len_next  = scan_len_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_vld_next    = ram_re;
        have_next      = have_reg;
        best_idx_next  = best_idx_reg;
        best_pt_next   = best_pt_reg;
        best_dist_next = best_dist_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        if (d_better)
        begin
            have_next      = 1'b1;
            best_idx_next  = d_idx;
            best_pt_next   = d_pt;
            best_dist_next = d_dist;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.operation == nps_pkg::OP_QUERY))
                begin
                    query_next     = {req.coord_x, req.coord_y, req.coord_z};
                    scan_len_next  = scan_len_calc;
                    issue_cnt_next = '0;
                    have_next      = 1'b0;
                    best_idx_next  = '0;
                    best_pt_next   = '0;
                    best_dist_next = '0;
                    state_next     = (scan_len_calc == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ram_re)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                else if (!rd_vld_reg && !d_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            have_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            issue_cnt_reg <= '0;
            scan_len_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            have_reg      <= have_next;
            rsp_valid_reg <= rsp_valid_next;
            issue_cnt_reg <= issue_cnt_next;
            scan_len_reg  <= scan_len_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg     <= query_next;
        rd_idx_reg    <= issue_cnt_reg[AW-1:0];
        best_idx_reg  <= best_idx_next;
        best_pt_reg   <= best_pt_next;
        best_dist_reg <= best_dist_next;
        if (rsp_load)
        begin
            rsp_found_reg <= have_reg;
            rsp_idx_reg   <= best_idx_ext[nps_pkg::IDX_W-1:0];
            rsp_pt_reg    <= best_pt_reg;
            rsp_dist_reg  <= best_dist_reg;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.found            = rsp_found_reg;
    assign rsp.nearest_index    = rsp_idx_reg;
    assign rsp.nearest_x        = rsp_pt_reg[PT_W-1 -: CB];
    assign rsp.nearest_y        = rsp_pt_reg[2*CB-1 -: CB];
    assign rsp.nearest_z        = rsp_pt_reg[CB-1:0];
    assign rsp.distance_squared = rsp_dist_reg;

endmodule
